// ===== rtl/button_click_press_detector_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button click and press detector
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_PRESS_DETECTOR_DEFINES_SVH
`define BUTTON_CLICK_PRESS_DETECTOR_DEFINES_SVH

// assert with reset disable
`define BCPD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assert that also holds during reset
`define BCPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Button click and press detector package
// Event codes, register indexes, reset values and the run record type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcpd_pkg;

   localparam int CLICK_COUNT_BITS_DEF = 8;
   localparam int RUN_SLOTS            = 3;
   localparam int CSR_INDEX_BITS       = 3;
   localparam int CSR_DATA_BITS        = 16;

   localparam logic [15:0] DEBOUNCE_RESET   = 16'd30;
   localparam logic [15:0] LONG_RESET       = 16'd800;
   localparam logic [15:0] EXTRA_LONG_RESET = 16'd3000;
   localparam logic [15:0] WINDOW_RESET     = 16'd350;

   typedef enum logic [2:0] {
      EV_PRESSED    = 3'd0,
      EV_RELEASED   = 3'd1,
      EV_CLICK      = 3'd2,
      EV_DOUBLE     = 3'd3,
      EV_TRIPLE     = 3'd4,
      EV_MULTI      = 3'd5,
      EV_LONG       = 3'd6,
      EV_EXTRA_LONG = 3'd7
   } event_code_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEBOUNCE   = 3'd0,
      CSR_LONG       = 3'd1,
      CSR_EXTRA_LONG = 3'd2,
      CSR_WINDOW     = 3'd3,
      CSR_LEVEL      = 3'd4
   } csr_index_type;

   typedef struct packed {
      event_code_type code;
      logic [7:0]     total;
   } event_type;

   typedef struct packed {
      logic [1:0]                    count;
      event_type [RUN_SLOTS-1:0]     slot;
      logic [31:0]                   stamp;
   } run_type;

   function automatic logic passed(logic [31:0] now, logic [31:0] start, logic [15:0] span);
      logic [31:0] diff;
      diff = now - start;
      return diff >= {16'h0000, span};
   endfunction

endpackage

// ===== rtl/bcpd_front.sv =====
// ----------------------------------------------------------------------------
// Button detector front end
// Debounces one sample per cycle while the run queue has room, updates
// press and click state and packs the sample's events into one run record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcpd_front import bcpd_pkg::*; #(
   parameter int CLICK_COUNT_BITS = CLICK_COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic [31:0]               req_now_time,
   input  logic                      req_pin_level,
   input  logic                      queue_full,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output logic                      run_push,
   output run_type                   run_data
);

   localparam int NCAND = 6;

   logic [15:0] debounce_ff, long_ff, xlong_ff, window_ff;
   logic        level_ff;

   logic                        raw_ff, stable_ff, long_rep_ff, xlong_rep_ff;
   logic [31:0]                 raw_time_ff, press_time_ff, rel_time_ff;
   logic [CLICK_COUNT_BITS-1:0] pend_ff;

   logic                        raw_in, stable_in, long_rep_in, xlong_rep_in;
   logic [31:0]                 raw_time_in, press_time_in, rel_time_in;
   logic [CLICK_COUNT_BITS-1:0] pend_in;

   logic                        accept, act, change, pressed_now, released_now;
   logic                        settle1, settle2, long_fire, xlong_fire;
   logic                        long_a, xlong_a;
   logic [CLICK_COUNT_BITS-1:0] pend_a, pend_b;
   logic [NCAND-1:0]            fire;
   event_type [NCAND-1:0]       cand;
   logic [2:0]                  cnt;
   run_type                     run;

   function automatic event_code_type settle_code(logic [CLICK_COUNT_BITS-1:0] p);
      if (p == CLICK_COUNT_BITS'(1)) return EV_CLICK;
      else if (p == CLICK_COUNT_BITS'(2)) return EV_DOUBLE;
      else if (p == CLICK_COUNT_BITS'(3)) return EV_TRIPLE;
      else return EV_MULTI;
   endfunction

   function automatic logic [7:0] to_total(logic [CLICK_COUNT_BITS-1:0] p);
      logic [CLICK_COUNT_BITS+7:0] ext;
      ext = {8'h00, p};
      return ext[7:0];
   endfunction

   assign accept = req_push && !queue_full;

   always_comb begin
      act          = (req_pin_level == level_ff);
      raw_in       = act;
      raw_time_in  = (act != raw_ff) ? req_now_time : raw_time_ff;
      change       = (stable_ff != raw_in) &&
                     passed(req_now_time, raw_time_in, debounce_ff);
      stable_in    = change ? raw_in : stable_ff;
      pressed_now  = change && raw_in;
      released_now = change && !raw_in;

      settle1       = pressed_now && (pend_ff != '0) &&
                      passed(req_now_time, rel_time_ff, window_ff);
      pend_a        = settle1 ? '0 : pend_ff;
      press_time_in = pressed_now ? req_now_time : press_time_ff;
      long_a        = pressed_now ? 1'b0 : long_rep_ff;
      xlong_a       = pressed_now ? 1'b0 : xlong_rep_ff;

      pend_b = pend_a;
      if (released_now) begin
         if (long_a || xlong_a) pend_b = '0;
         else if (pend_a != '1) pend_b = pend_a + CLICK_COUNT_BITS'(1);
      end
      rel_time_in = released_now ? req_now_time : rel_time_ff;

      settle2    = !stable_in && (pend_b != '0) &&
                   passed(req_now_time, rel_time_in, window_ff);
      pend_in    = settle2 ? '0 : pend_b;
      long_fire  = stable_in && !long_a && passed(req_now_time, press_time_in, long_ff);
      xlong_fire = stable_in && !long_fire && (xlong_ff != 16'h0000) && long_a &&
                   !xlong_a && passed(req_now_time, press_time_in, xlong_ff);
      long_rep_in  = long_a || long_fire;
      xlong_rep_in = xlong_a || xlong_fire;

      fire = {xlong_fire, long_fire, settle2, released_now, pressed_now, settle1};
      cand[0] = '{code: settle_code(pend_ff), total: to_total(pend_ff)};
      cand[1] = '{code: EV_PRESSED, total: 8'h00};
      cand[2] = '{code: EV_RELEASED, total: 8'h00};
      cand[3] = '{code: settle_code(pend_b), total: to_total(pend_b)};
      cand[4] = '{code: EV_LONG, total: 8'h00};
      cand[5] = '{code: EV_EXTRA_LONG, total: 8'h00};

      run       = '0;
      run.stamp = req_now_time;
      cnt       = 3'd0;
      for (int k = 0; k < NCAND; k++) begin
         if (fire[k] && cnt < 3'(RUN_SLOTS)) begin
            run.slot[cnt[1:0]] = cand[k];
            cnt = cnt + 3'd1;
         end
      end
      run.count = cnt[1:0];
   end

   assign run_push = accept && (cnt != 3'd0);
   assign run_data = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         long_ff     <= LONG_RESET;
         xlong_ff    <= EXTRA_LONG_RESET;
         window_ff   <= WINDOW_RESET;
         level_ff    <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:   debounce_ff <= csr_data;
            CSR_LONG:       long_ff     <= csr_data;
            CSR_EXTRA_LONG: xlong_ff    <= csr_data;
            CSR_WINDOW:     window_ff   <= csr_data;
            CSR_LEVEL:      level_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff        <= 1'b0;
         stable_ff     <= 1'b0;
         raw_time_ff   <= '0;
         press_time_ff <= '0;
         long_rep_ff   <= 1'b0;
         xlong_rep_ff  <= 1'b0;
         pend_ff       <= '0;
         rel_time_ff   <= '0;
      end else if (accept) begin
         raw_ff        <= raw_in;
         stable_ff     <= stable_in;
         raw_time_ff   <= raw_time_in;
         press_time_ff <= press_time_in;
         long_rep_ff   <= long_rep_in;
         xlong_rep_ff  <= xlong_rep_in;
         pend_ff       <= pend_in;
         rel_time_ff   <= rel_time_in;
      end
   end

endmodule

// ===== rtl/bcpd_queue.sv =====
// ----------------------------------------------------------------------------
// Button detector run queue
// Two-entry register queue of run records between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcpd_queue import bcpd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  run_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output run_type head
);

   run_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= ~rd_ptr_ff;
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/bcpd_back.sv =====
// ----------------------------------------------------------------------------
// Button detector back end
// Walks the slots of the head run record and presents one event per beat
// in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcpd_back import bcpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        queue_empty,
   input  run_type     queue_head,
   output logic        queue_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [2:0]  rsp_event_code,
   output logic [7:0]  rsp_click_total,
   output logic [31:0] rsp_event_time,
   output logic        rsp_last_of_run
);

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff;
   event_type   ev_ff;
   logic [31:0] time_ff;
   logic        last_ff;
   logic        load, take, last;

   assign load      = !valid_ff || rsp_pop;
   assign take      = load && !queue_empty;
   assign last      = (idx_ff == queue_head.count - 2'd1);
   assign queue_pop = take && last;
   assign idx_in    = last ? 2'd0 : idx_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= !queue_empty;
         if (take) idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ev_ff   <= queue_head.slot[idx_ff];
         time_ff <= queue_head.stamp;
         last_ff <= last;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_event_code  = ev_ff.code;
   assign rsp_click_total = ev_ff.total;
   assign rsp_event_time  = time_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== rtl/button_click_press_detector.sv =====
// ----------------------------------------------------------------------------
// Button click and press detector
// Debounced press/release, multi-click and long-press event generator.
//
//   channel  ports                     beat moves
//   req      req_push / req_full       one sample: time stamp and pin level
//   rsp      rsp_pop / rsp_empty       one event: code, clicks, time, last flag
//   csr      csr_valid / csr_ready     one register write: index and data
//
// A sample is taken in any cycle the two-entry run queue has room; the front
// end handles it in that cycle. Each event of a sample leaves the output
// register one per cycle while the result side pops, so a sample's events
// (up to three) hold the result side until the last is popped. Reset is
// synchronous and clears the control and state registers. A stalled result
// side backs up the queue and then req_full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_click_press_detector import bcpd_pkg::*; #(
   parameter int CLICK_COUNT_BITS = CLICK_COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [31:0]               req_now_time,
   input  logic                      req_pin_level,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [2:0]                rsp_event_code,
   output logic [7:0]                rsp_click_total,
   output logic [31:0]               rsp_event_time,
   output logic                      rsp_last_of_run,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic    run_push, q_full, q_empty, q_pop;
   run_type run_data, q_head;

   assign req_full  = q_full;
   assign csr_ready = 1'b1;

   bcpd_front #(.CLICK_COUNT_BITS(CLICK_COUNT_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_now_time  (req_now_time),
      .req_pin_level (req_pin_level),
      .queue_full    (q_full),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .run_push      (run_push),
      .run_data      (run_data)
   );

   bcpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (run_push),
      .push_data (run_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   bcpd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (q_empty),
      .queue_head      (q_head),
      .queue_pop       (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_event_code  (rsp_event_code),
      .rsp_click_total (rsp_click_total),
      .rsp_event_time  (rsp_event_time),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== rtl/bcpd_checker.sv =====
// ----------------------------------------------------------------------------
// Button detector port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_click_press_detector_defines.svh"

module bcpd_checker import bcpd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [2:0]  rsp_event_code,
   input logic [7:0]  rsp_click_total,
   input logic [31:0] rsp_event_time,
   input logic        rsp_last_of_run
);

   logic is_settle;

   assign is_settle = (rsp_event_code == EV_CLICK) || (rsp_event_code == EV_DOUBLE) ||
                      (rsp_event_code == EV_TRIPLE) || (rsp_event_code == EV_MULTI);

   `BCPD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty, "result not empty after reset")

   `BCPD_ASSERT(a_hold, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_event_code) && $stable(rsp_event_time) && $stable(rsp_last_of_run), "stalled result beat changed")

   `BCPD_ASSERT(a_total_zero, clock, reset, !rsp_empty && !is_settle |-> rsp_click_total == 8'h00, "click total on non click event")

   `BCPD_ASSERT(a_release_settle, clock, reset, !rsp_empty && rsp_pop && rsp_event_code == EV_RELEASED && !rsp_last_of_run |=> !rsp_empty && is_settle && $stable(rsp_event_time), "release not followed by settle")

endmodule

bind button_click_press_detector bcpd_checker u_bcpd_checker (.*);

// ===== tb/button_click_press_detector_tb.sv =====
// ----------------------------------------------------------------------------
// Button click and press detector testbench
// Sends timed pin samples through the request queue and predicts every
// event: debounce, press and release, long and extra long hold, and click
// counting with settle after the window. A scoreboard checks each popped
// event, field by field, in order. Register settings change between phases
// once the block is idle. The phases cover zero thresholds, full-scale
// thresholds and a click burst that settles well past a triple.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_click_press_detector_tb;
   import bcpd_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 4;
   localparam int CSR_SPARE_FIRST = int'(CSR_LEVEL) + 1;

   typedef struct {
      event_code_type code;
      logic [7:0]     total;
      logic [31:0]    stamp;
      logic           last;
   } click_event_type;

   class click_scoreboard;
      logic [15:0] debounce_span, long_ms, extra_ms, window_ms;
      logic active_lvl;
      logic raw_on, stable_on, long_done, extra_done;
      logic [31:0] raw_change_at, press_at, release_at;
      logic [CLICK_COUNT_BITS_DEF-1:0] clicks;
      click_event_type batch[$];
      click_event_type due[$];
      int errors;

      function new();
         debounce_span = DEBOUNCE_RESET;
         long_ms = LONG_RESET;
         extra_ms = EXTRA_LONG_RESET;
         window_ms = WINDOW_RESET;
         active_lvl = 1'b0;
         raw_on = 1'b0;
         stable_on = 1'b0;
         long_done = 1'b0;
         extra_done = 1'b0;
         raw_change_at = '0;
         press_at = '0;
         release_at = '0;
         clicks = '0;
         errors = 0;
      endfunction

      function void note_config(logic [2:0] idx, logic [15:0] data);
         case (idx)
            CSR_DEBOUNCE: begin
               debounce_span = data;
            end
            CSR_LONG: begin
               long_ms = data;
            end
            CSR_EXTRA_LONG: begin
               extra_ms = data;
            end
            CSR_WINDOW: begin
               window_ms = data;
            end
            CSR_LEVEL: begin
               active_lvl = data[0];
            end
            default: begin
            end
         endcase
      endfunction

      function bit elapsed(logic [31:0] now, logic [31:0] start, logic [15:0] span);
         logic [31:0] gap;
         gap = now - start;
         return gap >= {16'h0000, span};
      endfunction

      function void add_event(event_code_type code, logic [7:0] total, logic [31:0] now);
         click_event_type ev;
         ev.code = code;
         ev.total = total;
         ev.stamp = now;
         ev.last = 1'b0;
         batch.push_back(ev);
      endfunction

      function void settle_clicks(logic [31:0] now);
         event_code_type code;
         if (clicks == 0 || !elapsed(now, release_at, window_ms)) return;
         if (clicks == 1) code = EV_CLICK;
         else if (clicks == 2) code = EV_DOUBLE;
         else if (clicks == 3) code = EV_TRIPLE;
         else code = EV_MULTI;
         add_event(code, 8'(clicks), now);
         clicks = '0;
      endfunction

      function void note_sample(logic [31:0] now, logic pin);
         logic act, went_on, went_off;
         click_event_type ev;
         batch.delete();
         act = (pin == active_lvl);
         went_on = 1'b0;
         went_off = 1'b0;
         if (act != raw_on) begin
            raw_on = act;
            raw_change_at = now;
         end
         if (stable_on != raw_on && elapsed(now, raw_change_at, debounce_span)) begin
            stable_on = raw_on;
            went_on = stable_on;
            went_off = !stable_on;
         end
         if (went_on) begin
            settle_clicks(now);
            press_at = now;
            long_done = 1'b0;
            extra_done = 1'b0;
            add_event(EV_PRESSED, 8'd0, now);
         end
         if (went_off) begin
            if (long_done || extra_done) clicks = '0;
            else if (clicks != '1) clicks = clicks + CLICK_COUNT_BITS_DEF'(1);
            release_at = now;
            add_event(EV_RELEASED, 8'd0, now);
         end
         if (!stable_on) begin
            settle_clicks(now);
         end else if (!long_done && elapsed(now, press_at, long_ms)) begin
            long_done = 1'b1;
            add_event(EV_LONG, 8'd0, now);
         end else if (extra_ms != 0 && long_done && !extra_done &&
                      elapsed(now, press_at, extra_ms)) begin
            extra_done = 1'b1;
            add_event(EV_EXTRA_LONG, 8'd0, now);
         end
         if (batch.size() > 0) begin
            ev = batch.pop_back();
            ev.last = 1'b1;
            batch.push_back(ev);
         end
         foreach (batch[i]) due.push_back(batch[i]);
      endfunction

      task flag_mismatch(string msg);
         $display("%0t ns  mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_event(logic [2:0] code, logic [7:0] total, logic [31:0] stamp, logic last);
         click_event_type want;
         if (due.size() == 0) begin
            flag_mismatch($sformatf("unexpected event code %0d clicks %0d at %0d",
                                    code, total, stamp));
            return;
         end
         want = due.pop_front();
         if (code !== want.code || total !== want.total || stamp !== want.stamp ||
             last !== want.last)
            flag_mismatch($sformatf("got code %0d clicks %0d at %0d last %0b, want %0d %0d %0d %0b",
                                    code, total, stamp, last,
                                    want.code, want.total, want.stamp, want.last));
      endtask
   endclass

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [31:0]               req_now_time = '0;
   logic                      req_pin_level = 1'b0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [2:0]                rsp_event_code;
   logic [7:0]                rsp_click_total;
   logic [31:0]               rsp_event_time;
   logic                      rsp_last_of_run;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   click_scoreboard book = new();
   logic [31:0] stamp_ms = '0;
   int samples_sent = 0;
   int send_idle = 17;
   int recv_idle = 54;
   int quiet_cycles = 0;

   button_click_press_detector uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_now_time    (req_now_time),
      .req_pin_level   (req_pin_level),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_event_code  (rsp_event_code),
      .rsp_click_total (rsp_click_total),
      .rsp_event_time  (rsp_event_time),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            book.check_event(rsp_event_code, rsp_click_total, rsp_event_time, rsp_last_of_run);
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_sample(input logic [31:0] now, input logic pin);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_now_time <= now;
      req_pin_level <= pin;
      do @(posedge clock); while (req_full);
      book.note_sample(now, pin);
      stamp_ms = now;
      samples_sent++;
   endtask

   task automatic tick(input logic [31:0] delta, input logic pin);
      send_sample(stamp_ms + delta, pin);
   endtask

   // drop push and hold until every expected event has been popped
   task automatic quiesce(input int tail);
      req_push <= 1'b0;
      while (book.due.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      book.note_config(idx, data);
   endtask

   task automatic set_reg(input logic [2:0] idx, input logic [15:0] data);
      quiesce(SETTLE_CYCLES);
      write_csr(idx, data);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] deb, input logic [15:0] lng,
                            input logic [15:0] xl, input logic [15:0] win, input logic lvl);
      logic [15:0] lvl_word;
      lvl_word = 16'($urandom);
      lvl_word[0] = lvl;
      quiesce(SETTLE_CYCLES);
      write_csr(CSR_DEBOUNCE, deb);
      write_csr(CSR_LONG, lng);
      write_csr(CSR_EXTRA_LONG, xl);
      write_csr(CSR_WINDOW, win);
      write_csr(CSR_LEVEL, lvl_word);
      write_csr(3'($urandom_range(7, CSR_SPARE_FIRST)), 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic random_settings();
      configure(16'($urandom_range(6)), 16'($urandom_range(40, 8)),
                ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(90, 1)),
                16'($urandom_range(30)), 1'($urandom_range(1)));
   endtask

   function automatic logic [31:0] near(input logic [31:0] span);
      case ($urandom_range(4))
         0: return span - 1;
         1: return span;
         2: return span + 1;
         3: return $urandom_range(span);
         default: return span + $urandom_range(span + 1);
      endcase
   endfunction

   task automatic gesture();
      logic on_lvl;
      logic [31:0] deb, lng, win;
      on_lvl = book.active_lvl;
      deb = 32'(book.debounce_span);
      lng = 32'(book.long_ms);
      win = 32'(book.window_ms);
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(4, 1))
            tick(($urandom_range(3) == 0) ? $urandom : near(deb), 1'($urandom_range(1)));
      end else begin
         tick($urandom_range(1) ? 32'($urandom_range(win)) : near(win), on_lvl);
         repeat ($urandom_range(2)) begin
            tick($urandom_range(deb), ~on_lvl);
            tick($urandom_range(deb), on_lvl);
         end
         tick(near(deb), on_lvl);
         if ($urandom_range(99) < 40) repeat ($urandom_range(3, 1)) tick(near(lng), on_lvl);
         tick($urandom_range(deb), ~on_lvl);
         if ($urandom_range(1)) begin
            tick($urandom_range(deb), on_lvl);
            tick($urandom_range(deb), ~on_lvl);
         end
         tick(near(deb), ~on_lvl);
         if ($urandom_range(1)) tick(near(win), ~on_lvl);
      end
   endtask

   task automatic random_phase(input int count);
      int start;
      start = samples_sent;
      while (samples_sent - start < count) gesture();
   endtask

   // fast clicks with debounce off and a full window: settle as one multi
   task automatic click_burst();
      configure(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'($urandom_range(1)));
      repeat (20) begin
         tick($urandom_range(300, 1), book.active_lvl);
         tick($urandom_range(300, 1), ~book.active_lvl);
      end
      tick(32'd70000, ~book.active_lvl);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: debounce edge, long then extra long on later samples,
      // release after long, double click, press across the time wrap
      send_sample(32'd0, 1'b1);
      send_sample(32'd10, 1'b0);
      send_sample(32'd39, 1'b0);
      send_sample(32'd40, 1'b0);
      send_sample(32'd5000, 1'b0);
      send_sample(32'd5001, 1'b0);
      send_sample(32'd5100, 1'b1);
      send_sample(32'd5130, 1'b1);
      send_sample(32'd5200, 1'b0);
      send_sample(32'd5230, 1'b0);
      send_sample(32'd5240, 1'b1);
      send_sample(32'd5270, 1'b1);
      send_sample(32'd5300, 1'b0);
      send_sample(32'd5330, 1'b0);
      send_sample(32'd5340, 1'b1);
      send_sample(32'd5370, 1'b1);
      send_sample(32'd5720, 1'b1);
      send_sample(32'hFFFF_FFF0, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_000E, 1'b0);
      send_sample(32'h0000_0020, 1'b1);
      send_sample(32'h0000_003E, 1'b1);

      // zero thresholds: settle, pressed and long out of one sample
      configure(16'd0, 16'd100, 16'd0, 16'd5, 1'b1);
      send_sample(32'd1000, 1'b1);
      send_sample(32'd1001, 1'b0);
      set_reg(CSR_LONG, 16'd0);
      send_sample(32'd1010, 1'b1);
      send_sample(32'd1011, 1'b0);

      configure(16'd0, 16'($urandom_range(40, 5)), 16'd0, 16'd0, 1'b0);
      random_phase(25);
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      random_phase(25);
      random_settings();
      random_phase(25);

      send_idle = 54;
      recv_idle = 17;
      configure(16'd0, 16'd0, 16'($urandom_range(60)), 16'($urandom_range(20)),
                1'($urandom_range(1)));
      random_phase(25);
      random_settings();
      random_phase(25);
      random_settings();
      random_phase(25);

      send_idle = 0;
      recv_idle = 0;
      random_settings();
      random_phase(25);
      click_burst();

      quiesce(2 * SETTLE_CYCLES);
      if (book.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== button_click_press_detector.f =====
+incdir+rtl
rtl/bcpd_pkg.sv
rtl/bcpd_front.sv
rtl/bcpd_queue.sv
rtl/bcpd_back.sv
rtl/button_click_press_detector.sv
rtl/bcpd_checker.sv
tb/button_click_press_detector_tb.sv
